// ===== hw/rtl/lpg_pkg.sv =====
// line pixel generator: shared codes, widths and constants
package lpg_pkg;

    // fixed field widths
    localparam int ADDR_WIDTH  = 23;
    localparam int PITCH_WIDTH = 12;

    // pitch after reset
    localparam logic [PITCH_WIDTH-1:0] PITCH_RESET = 12'd800;

    // input beat mode codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // step direction of one axis
    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b10
    } dir_t;

endpackage

// ===== hw/rtl/lpg_if.sv =====
// line pixel generator: input and output channel interfaces

interface line_in_if #(
    parameter int COORD_WIDTH = 11,
    parameter int COLOR_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [COORD_WIDTH-1:0] start_x;
    logic [COORD_WIDTH-1:0] start_y;
    logic [COORD_WIDTH-1:0] end_x;
    logic [COORD_WIDTH-1:0] end_y;
    logic [COLOR_WIDTH-1:0] color;

    modport source (
        output valid, mode, start_x, start_y, end_x, end_y, color,
        input  ready
    );
    modport sink (
        input  valid, mode, start_x, start_y, end_x, end_y, color,
        output ready
    );
endinterface

interface pixel_out_if #(
    parameter int COORD_WIDTH = 11,
    parameter int COLOR_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic [22:0]            pixel_address;
    logic [COLOR_WIDTH-1:0] pixel_color;
    logic                   last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
        output ready
    );
endinterface

// ===== hw/rtl/lpg_setup.sv =====
// line pixel generator: per-axis deltas, directions and major distance of a new line
module lpg_setup
    import lpg_pkg::*;
#(
    parameter int COORD_WIDTH = 11
) (
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] start_y,
    input  logic [COORD_WIDTH-1:0] end_x,
    input  logic [COORD_WIDTH-1:0] end_y,
    output logic [COORD_WIDTH-1:0] delta_x,
    output logic [COORD_WIDTH-1:0] delta_y,
    output dir_t                   dir_x,
    output dir_t                   dir_y,
    output logic [COORD_WIDTH-1:0] distance
);

    always_comb
    begin
        if (end_x > start_x)
        begin
            delta_x = end_x - start_x;
            dir_x   = DIR_POS;
        end
        else if (end_x == start_x)
        begin
            delta_x = '0;
            dir_x   = DIR_NONE;
        end
        else
        begin
            delta_x = start_x - end_x;
            dir_x   = DIR_NEG;
        end

        if (end_y > start_y)
        begin
            delta_y = end_y - start_y;
            dir_y   = DIR_POS;
        end
        else if (end_y == start_y)
        begin
            delta_y = '0;
            dir_y   = DIR_NONE;
        end
        else
        begin
            delta_y = start_y - end_y;
            dir_y   = DIR_NEG;
        end
    end

    // major axis length
    assign distance = (delta_x > delta_y) ? delta_x : delta_y;

endmodule

// ===== hw/rtl/lpg_in_reg.sv =====
// line pixel generator: input register stage
module lpg_in_reg
    import lpg_pkg::*;
#(
    parameter int COORD_WIDTH = 11,
    parameter int COLOR_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    line_in_if.sink                line_in,
    output logic                   item_valid,
    input  logic                   item_take,
    output logic                   item_mode,
    output logic [COORD_WIDTH-1:0] item_start_x,
    output logic [COORD_WIDTH-1:0] item_start_y,
    output logic [COORD_WIDTH-1:0] item_end_x,
    output logic [COORD_WIDTH-1:0] item_end_y,
    output logic [COLOR_WIDTH-1:0] item_color
);

    logic                   valid_reg;
    logic                   valid_next;
    logic                   mode_reg;
    logic [COORD_WIDTH-1:0] start_x_reg;
    logic [COORD_WIDTH-1:0] start_y_reg;
    logic [COORD_WIDTH-1:0] end_x_reg;
    logic [COORD_WIDTH-1:0] end_y_reg;
    logic [COLOR_WIDTH-1:0] color_reg;
    logic                   beat_in;

    // take a new beat when empty, or whenever the held one leaves this cycle
    assign line_in.ready = !valid_reg || item_take;
    assign beat_in       = line_in.valid && line_in.ready;

    always_comb
    begin
        if (beat_in)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_in)
        begin
            mode_reg    <= line_in.mode;
            start_x_reg <= line_in.start_x;
            start_y_reg <= line_in.start_y;
            end_x_reg   <= line_in.end_x;
            end_y_reg   <= line_in.end_y;
            color_reg   <= line_in.color;
        end
    end

    assign item_valid   = valid_reg;
    assign item_mode    = mode_reg;
    assign item_start_x = start_x_reg;
    assign item_start_y = start_y_reg;
    assign item_end_x   = end_x_reg;
    assign item_end_y   = end_y_reg;
    assign item_color   = color_reg;

endmodule

// ===== hw/rtl/lpg_raster.sv =====
// line pixel generator: line state, error stepping and pixel result register
module lpg_raster
    import lpg_pkg::*;
#(
    parameter int COORD_WIDTH = 11,
    parameter int COLOR_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [PITCH_WIDTH-1:0] pitch,
    input  logic                   item_valid,
    output logic                   item_take,
    input  logic                   item_mode,
    input  logic [COORD_WIDTH-1:0] item_start_x,
    input  logic [COORD_WIDTH-1:0] item_start_y,
    input  logic [COORD_WIDTH-1:0] item_end_x,
    input  logic [COORD_WIDTH-1:0] item_end_y,
    input  logic [COLOR_WIDTH-1:0] item_color,
    pixel_out_if.source            pixel_out
);

    localparam int ERR_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = COORD_WIDTH + PITCH_WIDTH;

    // line state
    logic                   active_reg,   active_next;
    logic [COORD_WIDTH-1:0] cur_x_reg,    cur_x_next;
    logic [COORD_WIDTH-1:0] cur_y_reg,    cur_y_next;
    logic [COORD_WIDTH-1:0] delta_x_reg,  delta_x_next;
    logic [COORD_WIDTH-1:0] delta_y_reg,  delta_y_next;
    dir_t                   dir_x_reg,    dir_x_next;
    dir_t                   dir_y_reg,    dir_y_next;
    logic [COORD_WIDTH-1:0] dist_reg,     dist_next;
    logic [ERR_WIDTH-1:0]   err_x_reg,    err_x_next;
    logic [ERR_WIDTH-1:0]   err_y_reg,    err_y_next;
    logic [ERR_WIDTH-1:0]   left_reg,     left_next;
    logic [COLOR_WIDTH-1:0] color_reg,    color_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [COORD_WIDTH-1:0] out_x_reg;
    logic [COORD_WIDTH-1:0] out_y_reg;
    logic [ADDR_WIDTH-1:0]  out_addr_reg;
    logic [COLOR_WIDTH-1:0] out_color_reg;
    logic                   out_last_reg;

    // setup results
    logic [COORD_WIDTH-1:0] new_delta_x;
    logic [COORD_WIDTH-1:0] new_delta_y;
    dir_t                   new_dir_x;
    dir_t                   new_dir_y;
    logic [COORD_WIDTH-1:0] new_dist;

    logic                   out_free;
    logic                   is_start;
    logic                   emits;
    logic                   do_start;
    logic                   do_emit;
    logic [ERR_WIDTH-1:0]   sum_x;
    logic [ERR_WIDTH-1:0]   sum_y;
    logic                   move_x;
    logic                   move_y;
    logic [PROD_WIDTH-1:0]  row_offset;
    logic [ADDR_WIDTH-1:0]  addr;
    logic                   is_last;

    lpg_setup #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_setup (
        .start_x  (item_start_x),
        .start_y  (item_start_y),
        .end_x    (item_end_x),
        .end_y    (item_end_y),
        .delta_x  (new_delta_x),
        .delta_y  (new_delta_y),
        .dir_x    (new_dir_x),
        .dir_y    (new_dir_y),
        .distance (new_dist)
    );

    // only a pixel-producing beat waits for the result register
    assign out_free  = !out_valid_reg || pixel_out.ready;
    assign is_start  = (item_mode == MODE_START);
    assign emits     = !is_start && active_reg;
    assign item_take = item_valid && (!emits || out_free);
    assign do_start  = item_take && is_start;
    assign do_emit   = item_take && emits;

    assign sum_x   = err_x_reg + ERR_WIDTH'(delta_x_reg);
    assign sum_y   = err_y_reg + ERR_WIDTH'(delta_y_reg);
    assign move_x  = sum_x > ERR_WIDTH'(dist_reg);
    assign move_y  = sum_y > ERR_WIDTH'(dist_reg);
    assign is_last = (left_reg == ERR_WIDTH'(1));

    assign row_offset = PROD_WIDTH'(cur_y_reg) * PROD_WIDTH'(pitch);
    assign addr       = ADDR_WIDTH'(row_offset) + ADDR_WIDTH'(cur_x_reg);

    function automatic logic [COORD_WIDTH-1:0] step_coord(
        input logic [COORD_WIDTH-1:0] c,
        input dir_t                   d
    );
        logic [COORD_WIDTH-1:0] r;
        case (d)
            DIR_POS: r = c + COORD_WIDTH'(1);
            DIR_NEG: r = c - COORD_WIDTH'(1);
            default: r = c;
        endcase
        return r;
    endfunction

    always_comb
    begin
        active_next  = active_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        dir_x_next   = dir_x_reg;
        dir_y_next   = dir_y_reg;
        dist_next    = dist_reg;
        err_x_next   = err_x_reg;
        err_y_next   = err_y_reg;
        left_next    = left_reg;
        color_next   = color_reg;

        if (do_start)
        begin
            active_next  = 1'b1;
            cur_x_next   = item_start_x;
            cur_y_next   = item_start_y;
            delta_x_next = new_delta_x;
            delta_y_next = new_delta_y;
            dir_x_next   = new_dir_x;
            dir_y_next   = new_dir_y;
            dist_next    = new_dist;
            err_x_next   = '0;
            err_y_next   = '0;
            left_next    = ERR_WIDTH'(new_dist) + ERR_WIDTH'(2);
            color_next   = item_color;
        end
        else if (do_emit)
        begin
            if (move_x)
            begin
                err_x_next = sum_x - ERR_WIDTH'(dist_reg);
                cur_x_next = step_coord(cur_x_reg, dir_x_reg);
            end
            else
            begin
                err_x_next = sum_x;
            end
            if (move_y)
            begin
                err_y_next = sum_y - ERR_WIDTH'(dist_reg);
                cur_y_next = step_coord(cur_y_reg, dir_y_reg);
            end
            else
            begin
                err_y_next = sum_y;
            end
            left_next   = left_reg - ERR_WIDTH'(1);
            active_next = !is_last;
        end
    end

    always_comb
    begin
        if (do_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            dir_x_reg     <= DIR_NONE;
            dir_y_reg     <= DIR_NONE;
            dist_reg      <= '0;
            err_x_reg     <= '0;
            err_y_reg     <= '0;
            left_reg      <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            dir_x_reg     <= dir_x_next;
            dir_y_reg     <= dir_y_next;
            dist_reg      <= dist_next;
            err_x_reg     <= err_x_next;
            err_y_reg     <= err_y_next;
            left_reg      <= left_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_addr_reg  <= addr;
            out_color_reg <= color_reg;
            out_last_reg  <= is_last;
        end
    end

    assign pixel_out.valid         = out_valid_reg;
    assign pixel_out.pixel_x       = out_x_reg;
    assign pixel_out.pixel_y       = out_y_reg;
    assign pixel_out.pixel_address = out_addr_reg;
    assign pixel_out.pixel_color   = out_color_reg;
    assign pixel_out.last_pixel    = out_last_reg;

endmodule

// ===== hw/rtl/line_pixel_generator_core.sv =====
// line pixel generator: top level of the line rasteriser
//
// integer line rasteriser. a start beat (mode 0) latches both endpoints and a
// colour and works out the absolute deltas, the step direction of each axis and
// the major distance; it produces no pixel. every step beat (mode 1) while a
// line is active produces one pixel beat carrying x, y, the framebuffer word
// address x + y * pitch (low 23 bits) and the colour, then advances both error
// accumulators. a line gives distance + 2 pixels, the first one twice, and the
// final pixel carries last_pixel. step beats with no active line are consumed
// silently, and a start beat mid-line drops the old line. rate: one input beat
// per clock while the pixel output is not stalled; a step beat passes the input
// register, then the stepping logic into the result register. the rate is set
// by the error update loop and the one row-times-pitch multiplier ahead of the
// result register. pitch_reg resets to 800 and the user writes it through
// cfg_wr_en / cfg_wr_data only while the block is idle; it is not enforced.
module line_pixel_generator_core
    import lpg_pkg::*;
#(
    parameter int COORD_WIDTH = 11,
    parameter int COLOR_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [PITCH_WIDTH-1:0] cfg_wr_data,
    line_in_if.sink                line_in,
    pixel_out_if.source            pixel_out
);

    // pitch register; the user writes it only while idle, not enforced here
    logic [PITCH_WIDTH-1:0] pitch_reg;
    logic [PITCH_WIDTH-1:0] pitch_next;

    // held input beat between the register stage and the rasteriser
    logic                   item_valid;
    logic                   item_take;
    logic                   item_mode;
    logic [COORD_WIDTH-1:0] item_start_x;
    logic [COORD_WIDTH-1:0] item_start_y;
    logic [COORD_WIDTH-1:0] item_end_x;
    logic [COORD_WIDTH-1:0] item_end_y;
    logic [COLOR_WIDTH-1:0] item_color;

    assign pitch_next = cfg_wr_en ? cfg_wr_data : pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= PITCH_RESET;
        end
        else
        begin
            pitch_reg <= pitch_next;
        end
    end

    // input register: frees itself whenever the rasteriser takes its beat
    lpg_in_reg #(
        .COORD_WIDTH (COORD_WIDTH),
        .COLOR_WIDTH (COLOR_WIDTH)
    ) u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_in      (line_in),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item_mode    (item_mode),
        .item_start_x (item_start_x),
        .item_start_y (item_start_y),
        .item_end_x   (item_end_x),
        .item_end_y   (item_end_y),
        .item_color   (item_color)
    );

    // line state, stepping and the pixel result register
    lpg_raster #(
        .COORD_WIDTH (COORD_WIDTH),
        .COLOR_WIDTH (COLOR_WIDTH)
    ) u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .pitch        (pitch_reg),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item_mode    (item_mode),
        .item_start_x (item_start_x),
        .item_start_y (item_start_y),
        .item_end_x   (item_end_x),
        .item_end_y   (item_end_y),
        .item_color   (item_color),
        .pixel_out    (pixel_out)
    );

endmodule

// ===== hw/rtl/lpg_checker.sv =====
// line pixel generator: port-level assertion checker and its bind
module lpg_checker
    import lpg_pkg::*;
#(
    parameter int COORD_WIDTH = 11,
    parameter int COLOR_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_wr_en,
    input logic [PITCH_WIDTH-1:0] cfg_wr_data,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_mode,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [COORD_WIDTH-1:0] out_x,
    input logic [COORD_WIDTH-1:0] out_y,
    input logic [ADDR_WIDTH-1:0]  out_addr,
    input logic [COLOR_WIDTH-1:0] out_color,
    input logic                   out_last
);

    localparam int PROD_WIDTH = COORD_WIDTH + PITCH_WIDTH;

    logic                   step_beat;
    logic                   out_beat;
    logic [PITCH_WIDTH-1:0] pitch_reg;
    logic [31:0]            credit_reg;
    logic [31:0]            credit_next;
    logic [PROD_WIDTH-1:0]  row_offset;
    logic [ADDR_WIDTH-1:0]  expect_addr;

    assign step_beat   = in_valid && in_ready && (in_mode == MODE_STEP);
    assign out_beat    = out_valid && out_ready;
    assign row_offset  = PROD_WIDTH'(out_y) * PROD_WIDTH'(pitch_reg);
    assign expect_addr = ADDR_WIDTH'(row_offset) + ADDR_WIDTH'(out_x);

    // step beats taken in but not yet answered by a pixel beat (idle steps stay counted)
    always_comb
    begin
        credit_next = credit_reg;
        if (step_beat && !out_beat)
        begin
            credit_next = credit_reg + 32'd1;
        end
        else if (out_beat && !step_beat)
        begin
            credit_next = credit_reg - 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= PITCH_RESET;
            credit_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pitch_reg <= cfg_wr_data;
            end
            credit_reg <= credit_next;
        end
    end

    // stalled pixel beat holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_x) && $stable(out_y) && $stable(out_addr) &&
            $stable(out_color) && $stable(out_last);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("pixel beat changed while stalled");

    // address follows the pitch in force
    property p_addr;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> out_addr == expect_addr;
    endproperty
    a_addr: assert property (p_addr)
        else $error("pixel address does not match x + y * pitch");

    // every pixel beat answers an earlier step beat
    property p_credit;
        @(posedge clk) disable iff (!rst_n)
        out_beat |-> credit_reg != '0;
    endproperty
    a_credit: assert property (p_credit)
        else $error("pixel beat without an earlier step beat");

endmodule

bind line_pixel_generator_core lpg_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .COLOR_WIDTH (COLOR_WIDTH)
) u_lpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (line_in.valid),
    .in_ready    (line_in.ready),
    .in_mode     (line_in.mode),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .out_x       (pixel_out.pixel_x),
    .out_y       (pixel_out.pixel_y),
    .out_addr    (pixel_out.pixel_address),
    .out_color   (pixel_out.pixel_color),
    .out_last    (pixel_out.last_pixel)
);

// ===== dv/testbench.sv =====
// line pixel generator testbench: random and directed lines checked against a raster model
module testbench
    import lpg_pkg::*;
();

    localparam int CW           = 11;
    localparam int KW           = 32;
    localparam int COORD_MAX    = (1 << CW) - 1;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 240;

    typedef struct packed {
        logic          mode;
        logic [CW-1:0] start_x;
        logic [CW-1:0] start_y;
        logic [CW-1:0] end_x;
        logic [CW-1:0] end_y;
        logic [KW-1:0] color;
    } line_beat_t;

    typedef struct packed {
        logic [CW-1:0]         pixel_x;
        logic [CW-1:0]         pixel_y;
        logic [ADDR_WIDTH-1:0] pixel_address;
        logic [KW-1:0]         pixel_color;
        logic                  last_pixel;
    } pixel_t;

    // raster model of the block plus the queue of pixels still owed
    class pixel_scoreboard;
        logic [PITCH_WIDTH-1:0] pitch = PITCH_RESET;
        logic                   busy = 1'b0;
        logic [CW-1:0]          cur_x = '0;
        logic [CW-1:0]          cur_y = '0;
        logic [CW-1:0]          dist_x = '0;
        logic [CW-1:0]          dist_y = '0;
        dir_t                   dir_x = DIR_NONE;
        dir_t                   dir_y = DIR_NONE;
        logic [CW-1:0]          major = '0;
        logic [11:0]            err_x = '0;
        logic [11:0]            err_y = '0;
        logic [11:0]            left = '0;
        logic [KW-1:0]          line_color = '0;
        pixel_t                 expected_pixels[$];
        int                     failures = 0;

        function automatic logic [CW-1:0] span(logic [CW-1:0] from, logic [CW-1:0] to,
                                               output dir_t dir);
            if (to > from)
            begin
                dir = DIR_POS;
                return to - from;
            end
            dir = (to == from) ? DIR_NONE : DIR_NEG;
            return from - to;
        endfunction

        function automatic logic [CW-1:0] advance(logic [CW-1:0] c, dir_t dir);
            case (dir)
                DIR_POS: return c + CW'(1);
                DIR_NEG: return c - CW'(1);
                default: return c;
            endcase
        endfunction

        function void note_line_beat(line_beat_t b);
            pixel_t      p;
            logic [31:0] addr_sum;
            if (b.mode == MODE_START)
            begin
                dist_x     = span(b.start_x, b.end_x, dir_x);
                dist_y     = span(b.start_y, b.end_y, dir_y);
                major      = (dist_x > dist_y) ? dist_x : dist_y;
                cur_x      = b.start_x;
                cur_y      = b.start_y;
                err_x      = '0;
                err_y      = '0;
                left       = 12'(major) + 12'd2;
                line_color = b.color;
                busy       = 1'b1;
            end
            else if (busy)
            begin
                addr_sum        = 32'(cur_x) + 32'(cur_y) * 32'(pitch);
                p.pixel_x       = cur_x;
                p.pixel_y       = cur_y;
                p.pixel_address = addr_sum[ADDR_WIDTH-1:0];
                p.pixel_color   = line_color;
                p.last_pixel    = (left == 12'd1);
                expected_pixels.push_back(p);
                err_x = err_x + 12'(dist_x);
                err_y = err_y + 12'(dist_y);
                if (err_x > 12'(major))
                begin
                    err_x = err_x - 12'(major);
                    cur_x = advance(cur_x, dir_x);
                end
                if (err_y > 12'(major))
                begin
                    err_y = err_y - 12'(major);
                    cur_y = advance(cur_y, dir_y);
                end
                left = left - 12'd1;
                if (left == 12'd0)
                    busy = 1'b0;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel beat: x=%0d y=%0d addr=%0d colour=%h last=%0b",
                             got.pixel_x, got.pixel_y, got.pixel_address, got.pixel_color,
                             got.last_pixel);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.pixel_address !== want.pixel_address ||
                got.pixel_color !== want.pixel_color || got.last_pixel !== want.last_pixel)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("pixel mismatch: expected x=%0d y=%0d addr=%0d colour=%h last=%0b",
                             want.pixel_x, want.pixel_y, want.pixel_address, want.pixel_color,
                             want.last_pixel);
                    $display("                actual   x=%0d y=%0d addr=%0d colour=%h last=%0b",
                             got.pixel_x, got.pixel_y, got.pixel_address, got.pixel_color,
                             got.last_pixel);
                end
            end
        endfunction

        function int pending_count();
            return expected_pixels.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [PITCH_WIDTH-1:0] cfg_wr_data;
    logic [PITCH_WIDTH-1:0] pitch_plan [5];
    int                     source_burst = 0;
    int                     sink_burst = 0;
    pixel_scoreboard        sb = new();

    line_in_if   #(.COORD_WIDTH(CW), .COLOR_WIDTH(KW)) line_in ();
    pixel_out_if #(.COORD_WIDTH(CW), .COLOR_WIDTH(KW)) pixel_out ();

    line_pixel_generator_core #(
        .COORD_WIDTH (CW),
        .COLOR_WIDTH (KW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .line_in     (line_in),
        .pixel_out   (pixel_out)
    );

    always #6 clk = ~clk;

    function automatic line_beat_t random_beat(logic m);
        line_beat_t b;
        b.mode    = m;
        b.start_x = CW'($urandom_range(0, COORD_MAX));
        b.start_y = CW'($urandom_range(0, COORD_MAX));
        b.end_x   = CW'($urandom_range(0, COORD_MAX));
        b.end_y   = CW'($urandom_range(0, COORD_MAX));
        b.color   = KW'($urandom);
        return b;
    endfunction

    // endpoint within reach of base, clamped to the coordinate range
    function automatic logic [CW-1:0] near(logic [CW-1:0] base, int reach);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return CW'(v);
    endfunction

    task automatic send_beat(line_beat_t b);
        int gap;
        gap = (source_burst > 0) ? 0 : $urandom_range(0, 3);
        if (source_burst > 0)
            source_burst--;
        else if ($urandom_range(0, 49) == 0)
            source_burst = $urandom_range(20, 60);
        if (gap > 0)
        begin
            line_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        line_in.valid   <= 1'b1;
        line_in.mode    <= b.mode;
        line_in.start_x <= b.start_x;
        line_in.start_y <= b.start_y;
        line_in.end_x   <= b.end_x;
        line_in.end_y   <= b.end_y;
        line_in.color   <= b.color;
        @(posedge clk);
        while (!line_in.ready)
            @(posedge clk);
        sb.note_line_beat(b);
    endtask

    task automatic start_line(int sx, int sy, int ex, int ey, logic [KW-1:0] colour);
        line_beat_t b;
        b.mode    = MODE_START;
        b.start_x = CW'(sx);
        b.start_y = CW'(sy);
        b.end_x   = CW'(ex);
        b.end_y   = CW'(ey);
        b.color   = colour;
        send_beat(b);
    endtask

    task automatic step_line(int n);
        repeat (n) send_beat(random_beat(MODE_STEP));
    endtask

    // hold the input quiet until every owed pixel is back, then let the pipe settle
    task automatic drain_pixels();
        line_in.valid <= 1'b0;
        while (sb.pending_count() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pitch(logic [PITCH_WIDTH-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.pitch = value;
    endtask

    // mostly complete short lines; some cut short, some full-span, some stray beats
    task automatic run_phase(int budget);
        int         used;
        int         kind;
        int         reach;
        int         steps;
        int         dx;
        int         dy;
        int         major;
        line_beat_t b;
        used = 0;
        while (used < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind >= 95)
            begin
                repeat ($urandom_range(1, 4))
                    send_beat(random_beat(logic'($urandom_range(0, 1))));
                used++;
            end
            else
            begin
                b = random_beat(MODE_START);
                if (kind < 85)
                begin
                    reach   = ($urandom_range(0, 9) == 0) ? 120 : 12;
                    b.end_x = near(b.start_x, reach);
                    b.end_y = near(b.start_y, reach);
                end
                dx = int'(b.end_x) - int'(b.start_x);
                dy = int'(b.end_y) - int'(b.start_y);
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                major = (dx > dy) ? dx : dy;
                if (kind >= 85)
                    steps = $urandom_range(0, 8);
                else if (kind >= 75)
                    steps = $urandom_range(0, major + 1);
                else
                    steps = major + 2;
                send_beat(b);
                step_line(steps);
                used += steps + 1;
                // steps after the line has ended go nowhere
                if (kind >= 65 && kind < 75)
                    step_line($urandom_range(1, 3));
                if ($urandom_range(0, 39) == 0)
                    drain_pixels();
            end
        end
    endtask

    // pixel sink with random back-pressure
    initial
    begin
        int     stall;
        pixel_t got;
        pixel_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (sink_burst > 0) ? 0 : $urandom_range(0, 3);
            if (sink_burst > 0)
                sink_burst--;
            else if ($urandom_range(0, 49) == 0)
                sink_burst = $urandom_range(20, 60);
            if (stall > 0)
            begin
                pixel_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixel_out.ready <= 1'b1;
            @(posedge clk);
            while (!pixel_out.valid)
                @(posedge clk);
            got.pixel_x       = pixel_out.pixel_x;
            got.pixel_y       = pixel_out.pixel_y;
            got.pixel_address = pixel_out.pixel_address;
            got.pixel_color   = pixel_out.pixel_color;
            got.last_pixel    = pixel_out.last_pixel;
            sb.check_pixel(got);
        end
    end

    // watchdog: too long without a beat on either channel ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((line_in.valid && line_in.ready) || (pixel_out.valid && pixel_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        line_in.valid   <= 1'b0;
        line_in.mode    <= MODE_STEP;
        line_in.start_x <= '0;
        line_in.start_y <= '0;
        line_in.end_x   <= '0;
        line_in.end_y   <= '0;
        line_in.color   <= '0;
        pitch_plan[0] = 12'd4095;
        pitch_plan[1] = 12'd1;
        pitch_plan[2] = 12'd0;
        pitch_plan[3] = PITCH_WIDTH'($urandom_range(2, 4094));
        pitch_plan[4] = 12'd640;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed lines at the reset pitch
        step_line(1);                                   // step with no line
        start_line(0, 0, 0, 0, 32'h0000_0000);          // single point at origin
        step_line(2);
        step_line(1);                                   // line finished, step ignored
        start_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
        step_line(2);
        start_line(5, 9, 8, 7, 32'hA5A5_A5A5);
        step_line(1);
        start_line(COORD_MAX, 0, 0, COORD_MAX, 32'h5A5A_5A5A);  // drops the line above
        step_line(3);
        start_line(3, 1, 0, 4, 32'h0F0F_F0F0);          // diagonal, x falling
        step_line(5);
        step_line(1);

        run_phase(PHASE_ITEMS);
        foreach (pitch_plan[k])
        begin
            drain_pixels();
            write_pitch(pitch_plan[k]);
            run_phase(PHASE_ITEMS);
        end

        drain_pixels();
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending_count() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
